// ===== rtl/core/buddy_block_allocator_top_defines.svh =====
// Assertion macros shared by the buddy allocator checker.
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define BBA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define BBA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bba_pkg.sv =====
// Types, codes and helper functions of the buddy block allocator.
package bba_pkg;

    localparam int UNITS_W  = 16;
    localparam int WANT_W   = UNITS_W + 1;
    localparam int OFFSET_W = 6;
    localparam int BUNITS_W = 7;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_SIZE  = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOSPACE  = 2'd1;
    localparam logic [1:0] STAT_NOTALLOC = 2'd2;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [UNITS_W-1:0]  req_units;
        logic [OFFSET_W-1:0] block_offset;
    } req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [OFFSET_W-1:0] result_offset;
        logic [BUNITS_W-1:0] block_units;
    } resp_t;

    // Smallest power of two not below the request; zero counts as one.
    function automatic logic [WANT_W-1:0] round_up_pow2(input logic [UNITS_W-1:0] units);
        logic [UNITS_W-1:0] m;
        logic [WANT_W-1:0]  res;
        begin
            m = units - UNITS_W'(1);
            m = m | (m >> 1);
            m = m | (m >> 2);
            m = m | (m >> 4);
            m = m | (m >> 8);
            if (units <= UNITS_W'(1))
            begin
                res = WANT_W'(1);
            end
            else
            begin
                res = WANT_W'(m) + WANT_W'(1);
            end
            return res;
        end
    endfunction

endpackage

// ===== rtl/core/buddy_block_allocator_top.sv =====
// Binary buddy allocator over POOL_UNITS units. The free-size tree (2*POOL_UNITS-1 nodes, heap
// order) lives in one memory with a registered read port, and every request walks it one node
// read per cycle. After reset the tree is initialized by a sweep over every node, and req_stall
// stays high until that sweep is done. An allocate checks the root, walks down to the chosen
// block, whose depth is log2(POOL_UNITS/size), walks back up rewriting ancestors, loads the
// response register and returns to idle, where the next request is taken; a request that finds
// no space, or asks for the whole pool, goes from the root check straight to the response. A
// free walks up from the leaf to the used node, then on up to the root, and an offset that is
// not allocated walks up as far as the root; a size query stops once the used node is found.
// The single memory read port limits each walk to one node per cycle. One request is worked
// on at a time; the response word sits in an output register, so a new request may be taken
// while it waits.
module buddy_block_allocator_top
    import bba_pkg::*;
#(
    parameter int POOL_UNITS = 64
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    input  req_t  req,
    output logic  rsp_valid,
    input  logic  rsp_stall,
    output resp_t rsp
);

    localparam int TREE_NODES = 2 * POOL_UNITS - 1;
    localparam int AW         = $clog2(TREE_NODES);
    localparam int LW         = $clog2(POOL_UNITS) + 1;
    localparam int OW         = $clog2(POOL_UNITS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ROOT,
        S_DOWN,
        S_UP,
        S_FIND,
        S_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          type_reg, type_next;
    logic [WANT_W-1:0]   want_reg, want_next;
    logic [AW-1:0]       cur_reg, cur_next;
    logic [LW-1:0]       ns_reg, ns_next;
    logic [LW-1:0]       val_reg, val_next;
    logic [OW-1:0]       roff_reg, roff_next;
    resp_t               res_reg, res_next;
    resp_t               rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [LW-1:0]       mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [LW-1:0]       mem_rdata;
    logic                mem_ready;

    logic                accept;
    logic                off_in_pool;
    logic [AW-1:0]       leaf;
    logic [LW-1:0]       half;
    logic [AW-1:0]       left;
    logic [AW-1:0]       child;
    logic                go_left;
    logic [AW-1:0]       parent;
    logic [AW-1:0]       sib_cur;
    logic [AW-1:0]       sib_child;
    logic [AW-1:0]       sib_parent;
    logic [LW-1:0]       ns_up;
    logic [LW:0]         pair_sum;
    logic [LW-1:0]       merged;

    bba_tree_store #(
        .POOL_UNITS (POOL_UNITS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata),
        .ready   (mem_ready)
    );

    assign accept      = (state_reg == S_IDLE) && req_valid;
    assign off_in_pool = 32'(req.block_offset) < POOL_UNITS;
    assign leaf        = AW'(req.block_offset) + AW'(POOL_UNITS - 1);

    // Tree navigation around the current node.
    assign half       = ns_reg >> 1;
    assign left       = {cur_reg[AW-2:0], 1'b1};
    assign go_left    = WANT_W'(mem_rdata) >= want_reg;
    assign child      = go_left ? left : left + AW'(1);
    assign parent     = (cur_reg - AW'(1)) >> 1;
    assign sib_cur    = cur_reg[0] ? cur_reg + AW'(1) : cur_reg - AW'(1);
    assign sib_child  = child[0] ? child + AW'(1) : child - AW'(1);
    assign sib_parent = parent[0] ? parent + AW'(1) : parent - AW'(1);
    assign ns_up      = ns_reg << 1;
    assign pair_sum   = (LW+1)'(val_reg) + (LW+1)'(mem_rdata);

    // A parent whose two halves are entirely free becomes one free block.
    always_comb
    begin
        if (pair_sum == (LW+1)'(ns_up))
        begin
            merged = ns_up;
        end
        else if (val_reg > mem_rdata)
        begin
            merged = val_reg;
        end
        else
        begin
            merged = mem_rdata;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        type_next      = type_reg;
        want_next      = want_reg;
        cur_next       = cur_reg;
        ns_next        = ns_reg;
        val_next       = val_reg;
        roff_next      = roff_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mem_we         = 1'b0;
        mem_waddr      = cur_reg;
        mem_wdata      = '0;
        mem_raddr      = '0;

        case (state_reg)
            S_CLEAR:
            begin
                if (mem_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.req_type != REQ_ALLOC && off_in_pool)
                begin
                    mem_raddr = leaf;
                end
                if (accept)
                begin
                    type_next = req.req_type;
                    want_next = round_up_pow2(req.req_units);
                    roff_next = '0;
                    res_next  = '0;
                    case (req.req_type)
                        REQ_ALLOC:
                        begin
                            cur_next   = '0;
                            ns_next    = LW'(POOL_UNITS);
                            state_next = S_ROOT;
                        end
                        REQ_FREE, REQ_SIZE:
                        begin
                            cur_next = leaf;
                            ns_next  = LW'(1);
                            if (off_in_pool)
                            begin
                                state_next = S_FIND;
                            end
                            else
                            begin
                                res_next.status = STAT_NOTALLOC;
                                state_next      = S_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_ROOT:
            begin
                if (WANT_W'(mem_rdata) < want_reg)
                begin
                    res_next.status = STAT_NOSPACE;
                    state_next      = S_RESP;
                end
                else if (want_reg == WANT_W'(POOL_UNITS))
                begin
                    mem_we                = 1'b1;
                    mem_waddr             = '0;
                    mem_wdata             = '0;
                    res_next.status       = STAT_OK;
                    res_next.block_units  = BUNITS_W'(want_reg);
                    state_next            = S_RESP;
                end
                else
                begin
                    mem_raddr  = AW'(1);
                    state_next = S_DOWN;
                end
            end

            // The read in flight is the left child of the current node.
            S_DOWN:
            begin
                cur_next = child;
                ns_next  = half;
                if (!go_left)
                begin
                    roff_next = roff_reg + OW'(half);
                end
                if (WANT_W'(half) == want_reg)
                begin
                    mem_we                 = 1'b1;
                    mem_waddr              = child;
                    mem_wdata              = '0;
                    mem_raddr              = sib_child;
                    val_next               = '0;
                    res_next.status        = STAT_OK;
                    res_next.result_offset = OFFSET_W'(go_left ? roff_reg
                                                               : roff_reg + OW'(half));
                    res_next.block_units   = BUNITS_W'(want_reg);
                    state_next             = S_UP;
                end
                else
                begin
                    mem_raddr = {child[AW-2:0], 1'b1};
                end
            end

            // The read in flight is the sibling of the current node.
            S_UP:
            begin
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = merged;
                cur_next  = parent;
                val_next  = merged;
                ns_next   = ns_up;
                if (parent == '0)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    mem_raddr = sib_parent;
                end
            end

            // The read in flight is the current node on the way up from the leaf.
            S_FIND:
            begin
                if (mem_rdata != '0)
                begin
                    if (cur_reg == '0)
                    begin
                        res_next.status = STAT_NOTALLOC;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        cur_next  = parent;
                        ns_next   = ns_up;
                        mem_raddr = parent;
                    end
                end
                else
                begin
                    res_next.status      = STAT_OK;
                    res_next.block_units = BUNITS_W'(ns_reg);
                    if (type_reg == REQ_SIZE)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = cur_reg;
                        mem_wdata = ns_reg;
                        val_next  = ns_reg;
                        if (cur_reg == '0)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            mem_raddr  = sib_cur;
                            state_next = S_UP;
                        end
                    end
                end
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
            type_reg      <= '0;
            want_reg      <= '0;
            cur_reg       <= '0;
            ns_reg        <= '0;
            val_reg       <= '0;
            roff_reg      <= '0;
            res_reg       <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            type_reg      <= type_next;
            want_reg      <= want_next;
            cur_reg       <= cur_next;
            ns_reg        <= ns_next;
            val_reg       <= val_next;
            roff_reg      <= roff_next;
            res_reg       <= res_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/core/bba_tree_store.sv =====
// Node memory of the buddy tree with its post-reset initialization sweep.
module bba_tree_store
    import bba_pkg::*;
#(
    parameter int POOL_UNITS = 64
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic [$clog2(2*POOL_UNITS-1)-1:0]      wr_addr,
    input  logic [$clog2(POOL_UNITS):0]            wr_data,
    input  logic [$clog2(2*POOL_UNITS-1)-1:0]      rd_addr,
    output logic [$clog2(POOL_UNITS):0]            rd_data,
    output logic                                   ready
);

    localparam int TREE_NODES = 2 * POOL_UNITS - 1;
    localparam int AW         = $clog2(TREE_NODES);
    localparam int LW         = $clog2(POOL_UNITS) + 1;

    logic [LW-1:0] mem [TREE_NODES];

    logic          busy_reg;
    logic          busy_next;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    logic [LW-1:0] size_reg;
    logic [LW-1:0] size_next;
    logic [AW:0]   n1;
    logic [AW:0]   n2;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [LW-1:0] mem_wdata;
    logic [LW-1:0] rd_data_reg;

    // The sweep writes each node with its full subtree size; the size halves
    // whenever the next index opens a new tree level.
    always_comb
    begin
        n1        = (AW+1)'(idx_reg) + (AW+1)'(1);
        n2        = (AW+1)'(idx_reg) + (AW+1)'(2);
        busy_next = busy_reg;
        idx_next  = idx_reg;
        size_next = size_reg;
        if (busy_reg)
        begin
            idx_next = n1[AW-1:0];
            if ((n2 & n1) == '0)
            begin
                size_next = size_reg >> 1;
            end
            if (idx_reg == AW'(TREE_NODES - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            size_reg <= LW'(POOL_UNITS);
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            size_reg <= size_next;
        end
    end

    assign mem_we    = busy_reg || wr_en;
    assign mem_waddr = busy_reg ? idx_reg  : wr_addr;
    assign mem_wdata = busy_reg ? size_reg : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign ready   = !busy_reg;

endmodule

// ===== rtl/core/bba_checker.sv =====
// Port-level checker for the buddy block allocator, bound to the top level.
`include "buddy_block_allocator_top_defines.svh"

module bba_checker
    import bba_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  req_valid,
    input logic  req_stall,
    input logic  rsp_valid,
    input logic  rsp_stall,
    input resp_t rsp
);

    `BBA_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "response word changed while stalled")
    `BBA_ASSERT_NXT(a_busy_after_req, req_valid && !req_stall, req_stall, "second request taken while one is in work")
    `BBA_ASSERT_IMP(a_err_zero, rsp_valid && rsp.status != STAT_OK, rsp.block_units == '0 && rsp.result_offset == '0, "error response carries a size or offset")
    `BBA_ASSERT_IMP(a_pow2_size, rsp_valid && rsp.block_units != '0, $onehot(rsp.block_units), "block size is not a power of two")

endmodule

bind buddy_block_allocator_top bba_checker u_bba_checker (.*);

// ===== tb/tb_buddy_block_allocator_top.sv =====
// Self-checking testbench for the buddy block allocator with random request gaps and random response stalls.
`timescale 1ns / 1ps

module tb_buddy_block_allocator_top;
    import bba_pkg::*;

    localparam int POOL       = 64;
    localparam int NODES      = 2 * POOL - 1;
    localparam int LEVELS     = 7;
    localparam int RAND_ITEMS = 800;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_stall;
    req_t  req = '0;
    logic  rsp_valid;
    logic  rsp_stall = 1'b0;
    resp_t rsp;

    // Largest free run below each tree node, heap order.
    logic [6:0]  free_run [NODES];
    req_t        req_backlog [$];
    resp_t       rsp_due [$];
    logic [5:0]  live_offsets [$];
    int          fail_count = 0;

    int    send_gap = 0;
    int    send_calm = 0;
    logic  send_next;
    resp_t predicted;
    int    hold_gap = 0;
    int    hold_calm = 0;
    resp_t want_rsp;

    buddy_block_allocator_top #(.POOL_UNITS(POOL)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    task automatic clear_tree();
        int lvl;
        int n;
        for (lvl = 0; lvl < LEVELS; lvl++)
        begin
            for (n = (1 << lvl) - 1; n <= (2 << lvl) - 2; n++)
            begin
                free_run[n] = 7'(POOL >> lvl);
            end
        end
    endtask

    function automatic resp_t buddy_predict(input req_t r);
        resp_t o;
        int    want;
        int    idx;
        int    ns;
        int    sz;
        int    lsum;
        bit    hit;
        o = '0;
        case (r.req_type)
            REQ_ALLOC:
            begin
                want = 1;
                while (want < int'(r.req_units))
                begin
                    want = want << 1;
                end
                if (int'(free_run[0]) < want)
                begin
                    o.status = STAT_NOSPACE;
                end
                else
                begin
                    idx = 0;
                    for (ns = POOL; ns != want; ns = ns >> 1)
                    begin
                        if (int'(free_run[2 * idx + 1]) >= want)
                        begin
                            idx = 2 * idx + 1;
                        end
                        else
                        begin
                            idx = 2 * idx + 2;
                        end
                    end
                    free_run[idx] = '0;
                    o.result_offset = 6'((idx + 1) * ns - POOL);
                    o.block_units = 7'(want);
                    while (idx != 0)
                    begin
                        idx = (idx - 1) / 2;
                        free_run[idx] = (free_run[2 * idx + 1] > free_run[2 * idx + 2]) ?
                                        free_run[2 * idx + 1] : free_run[2 * idx + 2];
                    end
                end
            end
            REQ_FREE, REQ_SIZE:
            begin
                // Walk up from the leaf to the lowest node that is in use.
                idx = int'(r.block_offset) + POOL - 1;
                sz = 1;
                hit = 1'b1;
                while (hit && free_run[idx] != 0)
                begin
                    if (idx == 0)
                    begin
                        hit = 1'b0;
                    end
                    else
                    begin
                        idx = (idx - 1) / 2;
                        sz = sz << 1;
                    end
                end
                if (!hit)
                begin
                    o.status = STAT_NOTALLOC;
                end
                else
                begin
                    o.block_units = 7'(sz);
                    if (r.req_type == REQ_FREE)
                    begin
                        ns = sz;
                        free_run[idx] = 7'(ns);
                        while (idx != 0)
                        begin
                            idx = (idx - 1) / 2;
                            ns = ns << 1;
                            lsum = int'(free_run[2 * idx + 1]) + int'(free_run[2 * idx + 2]);
                            if (lsum == ns)
                            begin
                                free_run[idx] = 7'(ns);
                            end
                            else
                            begin
                                free_run[idx] = (free_run[2 * idx + 1] > free_run[2 * idx + 2]) ?
                                                free_run[2 * idx + 1] : free_run[2 * idx + 2];
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    // Mostly short gaps, a few long ones, none at all during a calm stretch.
    function automatic int pick_gap(input int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0 || r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Request driver: predicts every accepted word and then loads the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else
        begin
            send_next = req_valid;
            if (req_valid && !req_stall)
            begin
                predicted = buddy_predict(req);
                rsp_due.push_back(predicted);
                if (req.req_type == REQ_ALLOC && predicted.status == STAT_OK)
                begin
                    live_offsets.push_back(predicted.result_offset);
                end
                if (send_calm > 0)
                begin
                    send_calm--;
                end
                else if ($urandom_range(0, 49) == 0)
                begin
                    send_calm = $urandom_range(20, 60);
                end
                send_gap = pick_gap(send_calm);
                send_next = 1'b0;
            end
            if (!send_next)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (req_backlog.size() > 0)
                begin
                    req <= req_backlog.pop_front();
                    send_next = 1'b1;
                end
            end
            req_valid <= send_next;
        end
    end

    // Response monitor and random stall on the response channel.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_due.size() == 0)
                begin
                    $error("response word with none expected: status %0d offset %0d units %0d",
                           rsp.status, rsp.result_offset, rsp.block_units);
                    fail_count++;
                end
                else
                begin
                    want_rsp = rsp_due.pop_front();
                    if (rsp.status !== want_rsp.status)
                    begin
                        $error("status: expected %0d actual %0d", want_rsp.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.result_offset !== want_rsp.result_offset)
                    begin
                        $error("result_offset: expected %0d actual %0d",
                               want_rsp.result_offset, rsp.result_offset);
                        fail_count++;
                    end
                    if (rsp.block_units !== want_rsp.block_units)
                    begin
                        $error("block_units: expected %0d actual %0d",
                               want_rsp.block_units, rsp.block_units);
                        fail_count++;
                    end
                end
            end
            if (hold_calm > 0)
            begin
                hold_calm--;
            end
            else if ($urandom_range(0, 199) == 0)
            begin
                hold_calm = $urandom_range(50, 150);
            end
            if (hold_gap > 0)
            begin
                hold_gap--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    hold_gap = pick_gap(hold_calm);
                end
                rsp_stall <= 1'b0;
            end
        end
    end

    task automatic queue_req(input logic [1:0] kind, input int units, input int off);
        req_t item;
        item.req_type = kind;
        item.req_units = 16'(units);
        item.block_offset = 6'(off);
        req_backlog.push_back(item);
    endtask

    task automatic wait_drained();
        while (req_backlog.size() != 0 || req_valid || rsp_due.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        req_t item;
        int   count;
        int   r;
        int   k;
        int   pick;
        bit   paused;
        clear_tree();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: zero and oversized requests, blocks entered off their start,
        // offsets that were never allocated, the unused type and a full pool.
        queue_req(REQ_ALLOC, 0, 17);
        queue_req(REQ_SIZE, 16'hFFFF, 0);
        queue_req(REQ_ALLOC, 16'hFFFF, 63);
        queue_req(REQ_ALLOC, 3, 0);
        queue_req(REQ_SIZE, 0, 6);
        queue_req(REQ_FREE, 0, 5);
        queue_req(REQ_FREE, 0, 5);
        queue_req(REQ_SIZE, 0, 63);
        queue_req(REQ_UNUSED, 16'hFFFF, 63);
        queue_req(REQ_FREE, 0, 0);
        queue_req(REQ_ALLOC, 64, 0);
        queue_req(REQ_ALLOC, 1, 0);
        queue_req(REQ_SIZE, 0, 42);
        queue_req(REQ_FREE, 0, 63);
        queue_req(REQ_ALLOC, 32, 0);
        queue_req(REQ_ALLOC, 32, 0);
        queue_req(REQ_ALLOC, 1, 0);
        queue_req(REQ_FREE, 0, 32);
        queue_req(REQ_ALLOC, 16, 0);
        queue_req(REQ_ALLOC, 17, 0);
        queue_req(REQ_FREE, 0, 48);
        queue_req(REQ_FREE, 0, 40);
        queue_req(REQ_FREE, 0, 0);
        queue_req(REQ_ALLOC, 65, 0);
        wait_drained();

        count = 0;
        paused = 1'b0;
        while (count < RAND_ITEMS)
        begin
            // Keep the backlog short so frees track what is really allocated.
            while (req_backlog.size() > 2)
            begin
                @(negedge clk);
            end
            if (count == RAND_ITEMS / 2 && !paused)
            begin
                wait_drained();
                paused = 1'b1;
            end
            item.req_units = 16'($urandom);
            item.block_offset = 6'($urandom);
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                item.req_type = REQ_ALLOC;
                k = $urandom_range(0, 99);
                if (k < 65)
                begin
                    item.req_units = 16'($urandom_range(0, 8));
                end
                else if (k < 90)
                begin
                    item.req_units = 16'($urandom_range(9, 64));
                end
                count++;
            end
            else if (r < 80)
            begin
                item.req_type = REQ_FREE;
                if (live_offsets.size() > 0 && $urandom_range(0, 6) != 0)
                begin
                    pick = $urandom_range(0, live_offsets.size() - 1);
                    item.block_offset = live_offsets[pick];
                    live_offsets.delete(pick);
                end
                count++;
            end
            else if (r < 95)
            begin
                item.req_type = REQ_SIZE;
                if (live_offsets.size() > 0 && $urandom_range(0, 1) == 0)
                begin
                    item.block_offset = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
                end
                count++;
            end
            else
            begin
                item.req_type = REQ_UNUSED;
            end
            req_backlog.push_back(item);
        end

        wait_drained();
        repeat (64) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("buddy_block_allocator_top: match");
        end
        else
        begin
            $display("buddy_block_allocator_top: mismatch");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("buddy_block_allocator_top: mismatch");
        $finish;
    end

endmodule
